// ===== src/isa_pkg.sv =====
// ----------------------------------------------------------------------------
// isa_pkg: shared definitions for the indexed scatter accumulator
// Widths, command and status codes, and the parameter defaults.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int BIN_DEPTH_DEF   = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 11;
  localparam int TOTAL_W  = 48;
  localparam int STATUS_W = 2;

  localparam logic [INDEX_W-1:0] BIN_COUNT_RESET = 11'd1024;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ACC  = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

endpackage

// ===== src/isa_in_if.sv =====
// ----------------------------------------------------------------------------
// isa_in_if: request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface isa_in_if #(
  parameter int VALUE_WIDTH = isa_pkg::VALUE_WIDTH_DEF
);
  import isa_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic [INDEX_W-1:0]            bin_index;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, command, bin_index, value, input ready);
  modport sink   (input valid, command, bin_index, value, output ready);

endinterface

// ===== src/isa_out_if.sv =====
// ----------------------------------------------------------------------------
// isa_out_if: response channel
// Valid/ready channel carrying one bin total and its status per beat.
// ----------------------------------------------------------------------------
interface isa_out_if;
  import isa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] bin_total;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, bin_total, status, input ready);
  modport sink   (input valid, bin_total, status, output ready);

endinterface

// ===== src/indexed_scatter_accumulator.sv =====
// ----------------------------------------------------------------------------
// indexed_scatter_accumulator: scatter-add engine over a bin memory
// Accumulates, loads or reads 48-bit signed bins named by a one-based index.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  req      in   command, bin_index, value
//  rsp      out  bin_total, status
//  cfg      in   cfg_wr_en, cfg_wr_data (bin_count)
//
// One beat per cycle sustained while rsp is ready. Each request makes a single
// read-modify-write pass: stage 1 holds it with its read data, then the result
// register drives rsp.valid. After reset the memory is swept to zero over all
// BIN_DEPTH bins (1024 by default); req.ready stays low meanwhile, configuration
// writes still land. A stalled rsp holds the result register and the beat
// behind it, then req.ready drops.
// ----------------------------------------------------------------------------
module indexed_scatter_accumulator #(
  parameter int BIN_DEPTH   = isa_pkg::BIN_DEPTH_DEF,
  parameter int VALUE_WIDTH = isa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  isa_in_if.sink                        req,
  isa_out_if.source                     rsp,
  input  logic                          cfg_wr_en,
  input  logic [isa_pkg::INDEX_W-1:0]   cfg_wr_data
);
  import isa_pkg::*;

  localparam int ADDR_W = $clog2(BIN_DEPTH);

  logic [TOTAL_W-1:0] mem [BIN_DEPTH];

  logic [INDEX_W-1:0] bin_count;

  // Reset sweep
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // Request decode
  logic              req_accept;
  logic [31:0]       req_slot;
  logic [ADDR_W-1:0] req_addr;
  logic              req_in_range;

  // Stage 1: item waiting on its read data
  logic                          s1_valid;
  logic [CMD_W-1:0]              s1_cmd;
  logic [ADDR_W-1:0]             s1_addr;
  logic signed [VALUE_WIDTH-1:0] s1_value;
  logic                          s1_in_range;
  logic [TOTAL_W-1:0]            rd_data;
  logic                          s1_advance;
  logic                          s1_we;

  // Last write, used to forward into the next item
  logic                          wb_valid;
  logic [ADDR_W-1:0]             wb_addr;
  logic [TOTAL_W-1:0]            wb_data;

  logic signed [TOTAL_W-1:0] bin_cur;
  logic signed [TOTAL_W-1:0] value_ext;
  logic signed [TOTAL_W:0]   sum;
  logic signed [TOTAL_W-1:0] res_total_next;
  logic [STATUS_W-1:0]       res_status_next;

  // Result register
  logic                      out_valid;
  logic signed [TOTAL_W-1:0] out_total;
  logic [STATUS_W-1:0]       out_status;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TOTAL_W-1:0] mem_wdata;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !clr_active && (!s1_valid || s1_advance);
  assign req_accept = req.valid && req.ready;

  assign req_slot     = 32'(req.bin_index) - 32'd1;
  assign req_addr     = req_slot[ADDR_W-1:0];
  assign req_in_range = (req.bin_index != '0) && (req.bin_index <= bin_count) &&
                        (32'(req.bin_index) <= 32'(BIN_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RESET;
    end else if (cfg_wr_en) begin
      bin_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(BIN_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // The read issues at the accepting edge, so the previous item's write at the
  // same edge is not yet visible; wb_* covers that one case.
  always_comb begin
    if (wb_valid && wb_addr == s1_addr) begin
      bin_cur = wb_data;
    end else begin
      bin_cur = rd_data;
    end
    value_ext       = TOTAL_W'(s1_value);
    sum             = (TOTAL_W+1)'(bin_cur) + (TOTAL_W+1)'(value_ext);
    s1_we           = 1'b0;
    res_total_next  = bin_cur;
    res_status_next = STATUS_OK;
    if (!s1_in_range) begin
      res_total_next  = '0;
      res_status_next = STATUS_RANGE;
    end else begin
      case (s1_cmd)
        CMD_ACC: begin
          s1_we = 1'b1;
          if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
            res_total_next  = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
            res_status_next = STATUS_SAT;
          end else begin
            res_total_next = sum[TOTAL_W-1:0];
          end
        end
        CMD_LOAD: begin
          s1_we          = 1'b1;
          res_total_next = value_ext;
        end
        default: begin
          res_total_next = bin_cur;
        end
      endcase
    end
  end

  assign mem_we    = clr_active || (s1_advance && s1_we);
  assign mem_waddr = clr_active ? clr_addr : s1_addr;
  assign mem_wdata = clr_active ? '0 : res_total_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_accept) begin
      rd_data <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance && s1_we) begin
        wb_valid <= 1'b1;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_cmd      <= req.command;
      s1_addr     <= req_addr;
      s1_value    <= req.value;
      s1_in_range <= req_in_range;
    end
    if (s1_advance && s1_we) begin
      wb_addr <= s1_addr;
      wb_data <= res_total_next;
    end
    if (s1_advance) begin
      out_total  <= res_total_next;
      out_status <= res_status_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.bin_total = out_total;
  assign rsp.status    = out_status;

`ifndef SYNTHESIS
  a_no_req_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !req.ready)
    else $error("request taken during memory clear");

  a_no_item_write_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !(s1_advance && s1_we))
    else $error("item write collides with memory clear");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_SAT) |->
      (rsp.bin_total == TOTAL_MAX || rsp.bin_total == TOTAL_MIN))
    else $error("saturated result not at a limit");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_RANGE) |-> (rsp.bin_total == '0))
    else $error("out-of-range result carries a nonzero total");
`endif

endmodule
